// File: hdl/txf_pkg.sv
`timescale 1ns / 1ps

package txf_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_FORMAT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_ENTRIES = 1'd1;

	// default palette depth
	localparam int PALETTE_DEPTH_DEF = 256;

	// texel format codes
	localparam logic [3:0] FMT_RGBA32 = 4'd0;
	localparam logic [3:0] FMT_RGB24 = 4'd1;
	localparam logic [3:0] FMT_RGBA16 = 4'd2;
	localparam logic [3:0] FMT_RGB15 = 4'd3;
	localparam logic [3:0] FMT_IA16 = 4'd4;
	localparam logic [3:0] FMT_IA8 = 4'd5;
	localparam logic [3:0] FMT_I8 = 4'd6;
	localparam logic [3:0] FMT_IA4 = 4'd7;
	localparam logic [3:0] FMT_I4 = 4'd8;
	localparam logic [3:0] FMT_CI8_RGBA16 = 4'd9;
	localparam logic [3:0] FMT_CI8_IA16 = 4'd10;
	localparam logic [3:0] FMT_CI4_RGBA16 = 4'd11;
	localparam logic [3:0] FMT_CI4_IA16 = 4'd12;

	// item operation codes
	localparam logic OP_DECODE = 1'b0;
	localparam logic OP_PAL_WRITE = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [31:0] texel_word;
		logic        odd_column;
		logic        last_texel;
		logic [7:0]  entry_index;
		logic [15:0] entry_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic       substituted;
		logic       stored_alpha;
		logic       last_pixel;
	} out_item_t;

	// channel widening by bit replication
	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic logic [7:0] widen3(input logic [2:0] v);
		return {v, v, v[2:1]};
	endfunction

	// 5551 word to {r, g, b, a}
	function automatic logic [31:0] from5551(input logic [15:0] p);
		return {widen5(p[15:11]), widen5(p[10:6]), widen5(p[5:1]), {8{p[0]}}};
	endfunction

endpackage

// File: hdl/texel_format_to_rgba32_top.sv
`timescale 1ns / 1ps

// Texel to RGBA8888 converter. One beat is accepted per clock unless in_stall
// is high; a decode beat goes through stage 1 (palette read at the accepting
// edge) and the output register to become a pixel; palette write beats give no
// pixel. The palette sits in a single-port-write, one-read synchronous memory
// of PALETTE_DEPTH 16-bit words, read at the edge the texel beat is taken, so
// a palette write is seen by the very next texel. The palette holds nothing
// useful until written. Colour-index lookups at or beyond palette_entries, and
// unknown formats, give magenta with substituted set. The user must write
// configuration only while no beat is in flight; this is not enforced.
module texel_format_to_rgba32_top #(
	parameter int PALETTE_DEPTH = txf_pkg::PALETTE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  txf_pkg::in_item_t                     in_item,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output txf_pkg::out_item_t                    out_item,
	input  logic                                  cfg_we,
	input  logic [txf_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [txf_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import txf_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

	logic [3:0]  fmt_q;
	logic [8:0]  pal_entries_q;

	logic [15:0] pal_mem [PALETTE_DEPTH];

	logic        s1_valid_s1;
	logic [31:0] word_s1;
	logic        odd_s1;
	logic        last_s1;
	logic        idx_bad_s1;
	logic [15:0] pal_data_s1;

	logic        out_valid_q;
	out_item_t   out_q;

	logic        out_free;
	logic        in_accept;
	logic        dec_accept;
	logic        wr_en;
	logic [3:0]  in_nib;
	logic [7:0]  in_idx;
	out_item_t   dec;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGBA32;
			pal_entries_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEXEL_FORMAT: fmt_q <= cfg_data[3:0];
				CFG_PALETTE_ENTRIES: pal_entries_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_s1 && !out_free;
	assign in_accept = in_valid && !in_stall;
	assign dec_accept = in_accept && (in_item.operation == OP_DECODE);
	assign wr_en = in_accept && (in_item.operation == OP_PAL_WRITE)
		&& ({1'b0, in_item.entry_index} < DEPTH_W);

	// palette index of the incoming texel
	assign in_nib = in_item.odd_column ? in_item.texel_word[3:0] : in_item.texel_word[7:4];
	assign in_idx = (fmt_q == FMT_CI8_RGBA16 || fmt_q == FMT_CI8_IA16)
		? in_item.texel_word[7:0] : {4'b0, in_nib};

	// palette memory write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			pal_mem[in_item.entry_index[AW-1:0]] <= in_item.entry_value;
		end
	end

	// palette memory read
	always_ff @(posedge clk) begin
		if (dec_accept) begin
			pal_data_s1 <= pal_mem[in_idx[AW-1:0]];
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			s1_valid_s1 <= (in_item.operation == OP_DECODE);
		end else if (out_free) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (dec_accept) begin
			word_s1 <= in_item.texel_word;
			odd_s1 <= in_item.odd_column;
			last_s1 <= in_item.last_texel;
			idx_bad_s1 <= ({1'b0, in_idx} >= pal_entries_q) || ({1'b0, in_idx} >= DEPTH_W);
		end
	end

	// texel decode
	always_comb begin
		logic [3:0]  nib;
		logic [7:0]  lo8;
		logic [15:0] lo16;
		logic [31:0] c;
		logic        sub;
		nib = odd_s1 ? word_s1[3:0] : word_s1[7:4];
		lo8 = word_s1[7:0];
		lo16 = word_s1[15:0];
		c = '0;
		sub = 1'b0;
		case (fmt_q)
			FMT_RGBA32: c = word_s1;
			FMT_RGB24: c = {word_s1[31:8], 8'hff};
			FMT_RGBA16: c = from5551(lo16);
			FMT_RGB15: c = from5551(lo16) | 32'h0000_00ff;
			FMT_IA16: c = {lo16[15:8], lo16[15:8], lo16[15:8], lo16[7:0]};
			FMT_IA8: c = {widen4(lo8[7:4]), widen4(lo8[7:4]), widen4(lo8[7:4]),
				widen4(lo8[3:0])};
			FMT_I8: c = {lo8, lo8, lo8, lo8};
			FMT_IA4: c = {widen3(nib[3:1]), widen3(nib[3:1]), widen3(nib[3:1]),
				{8{nib[0]}}};
			FMT_I4: c = {widen4(nib), widen4(nib), widen4(nib), widen4(nib)};
			FMT_CI8_RGBA16, FMT_CI4_RGBA16: begin
				sub = idx_bad_s1;
				c = from5551(pal_data_s1);
			end
			FMT_CI8_IA16, FMT_CI4_IA16: begin
				sub = idx_bad_s1;
				c = {pal_data_s1[15:8], pal_data_s1[15:8], pal_data_s1[15:8],
					pal_data_s1[7:0]};
			end
			default: sub = 1'b1;
		endcase
		// magenta on bad index or format
		if (sub) begin
			c = 32'hff00_ffff;
		end
		dec.red = c[31:24];
		dec.green = c[23:16];
		dec.blue = c[15:8];
		dec.alpha = c[7:0];
		dec.substituted = sub;
		dec.stored_alpha = fmt_q inside {FMT_RGBA32, FMT_RGBA16, FMT_IA16, FMT_IA8,
			FMT_IA4, FMT_CI8_RGBA16, FMT_CI8_IA16, FMT_CI4_RGBA16, FMT_CI4_IA16};
		dec.last_pixel = last_s1;
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_free && s1_valid_s1) begin
			out_q <= dec;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

endmodule

// File: sim/texel_format_to_rgba32_top_tb.sv
`timescale 1ns / 1ps

module texel_format_to_rgba32_top_tb;
	import txf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;
	localparam int RAND_PHASES = 30;
	localparam int BEATS_PER_PHASE = 26;

	// golden texel decoder with its own copy of the palette and registers
	class pixel_scoreboard;
		logic [3:0] fmt;
		logic [8:0] pal_count;
		logic [15:0] pal [256];
		out_item_t awaited_pixels [$];
		int unsigned fails;

		function new();
			fmt = FMT_RGBA32;
			pal_count = '0;
			fails = 0;
			foreach (pal[i]) pal[i] = '0;
		endfunction

		function logic [7:0] spread5(logic [4:0] v);
			return ({3'b000, v} << 3) | ({3'b000, v} >> 2);
		endfunction

		function logic [7:0] spread4(logic [3:0] v);
			return {4'h0, v} * 8'h11;
		endfunction

		function logic [7:0] spread3(logic [2:0] v);
			return ({5'b0, v} << 5) | ({5'b0, v} << 2) | ({5'b0, v} >> 1);
		endfunction

		function logic [31:0] unpack5551(logic [15:0] p);
			return {spread5(p[15:11]), spread5(p[10:6]), spread5(p[5:1]),
				p[0] ? 8'hff : 8'h00};
		endfunction

		function logic alpha_bearing(logic [3:0] f);
			case (f)
				FMT_RGBA32, FMT_RGBA16, FMT_IA16, FMT_IA8, FMT_IA4,
				FMT_CI8_RGBA16, FMT_CI8_IA16, FMT_CI4_RGBA16, FMT_CI4_IA16: return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_TEXEL_FORMAT)
				fmt = val[3:0];
			else if (idx == CFG_PALETTE_ENTRIES)
				pal_count = val;
		endfunction

		function out_item_t decode_texel(in_item_t it);
			out_item_t r;
			logic [31:0] w;
			logic [7:0] lo8;
			logic [15:0] lo16;
			logic [3:0] nib;
			logic [7:0] idx;
			logic [15:0] p;
			logic bad;
			w = it.texel_word;
			lo8 = w[7:0];
			lo16 = w[15:0];
			nib = it.odd_column ? lo8[3:0] : lo8[7:4];
			bad = 1'b0;
			r = '0;
			case (fmt)
				FMT_RGBA32, FMT_RGB24: begin
					r.red = w[31:24];
					r.green = w[23:16];
					r.blue = w[15:8];
					r.alpha = (fmt == FMT_RGB24) ? 8'hff : w[7:0];
				end
				FMT_RGBA16, FMT_RGB15: begin
					{r.red, r.green, r.blue, r.alpha} = unpack5551(lo16);
					if (fmt == FMT_RGB15)
						r.alpha = 8'hff;
				end
				FMT_IA16: begin
					{r.red, r.green, r.blue} = {3{lo16[15:8]}};
					r.alpha = lo16[7:0];
				end
				FMT_IA8: begin
					{r.red, r.green, r.blue} = {3{spread4(lo8[7:4])}};
					r.alpha = spread4(lo8[3:0]);
				end
				FMT_I8: begin
					{r.red, r.green, r.blue, r.alpha} = {4{lo8}};
				end
				FMT_IA4: begin
					{r.red, r.green, r.blue} = {3{spread3(nib[3:1])}};
					r.alpha = nib[0] ? 8'hff : 8'h00;
				end
				FMT_I4: begin
					{r.red, r.green, r.blue, r.alpha} = {4{spread4(nib)}};
				end
				FMT_CI8_RGBA16, FMT_CI8_IA16, FMT_CI4_RGBA16, FMT_CI4_IA16: begin
					idx = (fmt == FMT_CI8_RGBA16 || fmt == FMT_CI8_IA16) ? lo8 : {4'h0, nib};
					// lookups past the valid entries fall back to magenta
					if ({1'b0, idx} >= pal_count) begin
						bad = 1'b1;
					end else begin
						p = pal[idx];
						if (fmt == FMT_CI8_RGBA16 || fmt == FMT_CI4_RGBA16) begin
							{r.red, r.green, r.blue, r.alpha} = unpack5551(p);
						end else begin
							{r.red, r.green, r.blue} = {3{p[15:8]}};
							r.alpha = p[7:0];
						end
					end
				end
				default: bad = 1'b1;
			endcase
			if (bad) begin
				r.red = 8'hff;
				r.green = 8'h00;
				r.blue = 8'hff;
				r.alpha = 8'hff;
			end
			r.substituted = bad;
			r.stored_alpha = alpha_bearing(fmt);
			r.last_pixel = it.last_texel;
			return r;
		endfunction

		// palette writes update the copy, texels queue a pixel
		function void note_beat(in_item_t it);
			if (it.operation == OP_PAL_WRITE)
				pal[it.entry_index] = it.entry_value;
			else
				awaited_pixels.push_back(decode_texel(it));
		endfunction

		function void field_check(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_pixel(out_item_t got);
			out_item_t want;
			if (awaited_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual %h", $time, got);
				fails++;
				return;
			end
			want = awaited_pixels.pop_front();
			field_check("red", want.red, got.red);
			field_check("green", want.green, got.green);
			field_check("blue", want.blue, got.blue);
			field_check("alpha", want.alpha, got.alpha);
			field_check("substituted", {7'b0, want.substituted}, {7'b0, got.substituted});
			field_check("stored_alpha", {7'b0, want.stored_alpha}, {7'b0, got.stored_alpha});
			field_check("last_pixel", {7'b0, want.last_pixel}, {7'b0, got.last_pixel});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_item;
	logic out_valid;
	logic out_stall;
	out_item_t out_item;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pixel_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;

	texel_format_to_rgba32_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// beats on both channels, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_pixel(out_item);
			if (in_valid && !in_stall)
				sb.note_beat(in_item);
		end
	end

	// receiver: random stalls, or a long hold-off when asked for
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				out_stall <= 1'b1;
				hold_left = HOLD_CYCLES - 1;
				hold_req = 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// give up when nothing moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_beat(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// drain, let palette writes settle, then write both registers
	task automatic settle_and_configure(input logic [3:0] f, input logic [8:0] n);
		in_valid <= 1'b0;
		while (sb.awaited_pixels.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_TEXEL_FORMAT;
		cfg_data <= {5'b0, f};
		sb.set_reg(CFG_TEXEL_FORMAT, {5'b0, f});
		@(negedge clk);
		cfg_index <= CFG_PALETTE_ENTRIES;
		cfg_data <= n;
		sb.set_reg(CFG_PALETTE_ENTRIES, n);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic in_item_t texel_beat(logic [31:0] w, logic odd, logic last);
		in_item_t it;
		it.operation = OP_DECODE;
		it.texel_word = w;
		it.odd_column = odd;
		it.last_texel = last;
		it.entry_index = 8'($urandom_range(255));
		it.entry_value = 16'($urandom_range(16'hffff));
		return it;
	endfunction

	initial begin
		in_item_t it;
		logic [3:0] f;
		logic [8:0] n;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_req = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 56;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every palette entry so no lookup reads an unwritten word
		for (int i = 0; i < 256; i++) begin
			it = texel_beat($urandom(), 1'($urandom_range(1)), 1'($urandom_range(1)));
			it.operation = OP_PAL_WRITE;
			it.entry_index = 8'(i);
			it.entry_value = 16'($urandom_range(16'hffff));
			send_beat(it);
		end

		// directed: every format code, each at an extreme of the texel word
		for (int k = 0; k < 16; k++) begin
			f = 4'(k);
			if (f >= FMT_CI8_RGBA16 && f <= FMT_CI4_IA16) begin
				settle_and_configure(f, 9'd16);
				// index 15 is the last valid entry, 0xff is beyond it for 8-bit indices
				send_beat(texel_beat(32'h0000000f, 1'b1, 1'b0));
				send_beat(texel_beat(32'hffffffff, 1'b0, 1'b1));
			end else begin
				settle_and_configure(f, 9'd0);
				if (k % 2 == 0)
					send_beat(texel_beat(32'hffffffff, 1'b0, 1'b1));
				else
					send_beat(texel_beat(32'h00000000, 1'b1, 1'b0));
			end
		end
		settle_and_configure(FMT_CI8_RGBA16, 9'd256);
		send_beat(texel_beat(32'h000000ff, 1'b0, 1'b1));
		settle_and_configure(FMT_CI4_IA16, 9'd0);
		send_beat(texel_beat(32'h00000000, 1'b0, 1'b0));
		settle_and_configure(FMT_CI8_IA16, 9'd16);
		send_beat(texel_beat(32'h00000010, 1'b1, 1'b0));

		// random phases, each under its own register setting
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES / 3) begin
				send_idle_pct = 56;
				recv_idle_pct = 38;
			end else if (p == 2 * RAND_PHASES / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (p < 16)
				f = 4'(p);
			else if ($urandom_range(1) == 1)
				f = 4'($urandom_range(FMT_CI8_RGBA16, FMT_CI4_IA16));
			else
				f = 4'($urandom_range(15));
			case ($urandom_range(4))
				0: n = 9'd0;
				1: n = 9'd256;
				2: n = 9'd16;
				3: n = 9'($urandom_range(1, 255));
				default: n = 9'($urandom_range(1, 20));
			endcase
			settle_and_configure(f, n);
			if (p == RAND_PHASES - 2)
				hold_req = 1'b1;
			repeat (BEATS_PER_PHASE) begin
				it = texel_beat($urandom(), 1'($urandom_range(1)), $urandom_range(7) == 0);
				if ($urandom_range(99) < 20)
					it.operation = OP_PAL_WRITE;
				// push 8-bit colour indices around the palette boundary
				if ((f == FMT_CI8_RGBA16 || f == FMT_CI8_IA16) && $urandom_range(1) == 1)
					it.texel_word[7:0] = 8'(n + $urandom_range(2) - 1);
				send_beat(it);
			end
		end

		in_valid <= 1'b0;
		while (sb.awaited_pixels.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: texel_format_to_rgba32_top.f
hdl/txf_pkg.sv
hdl/texel_format_to_rgba32_top.sv
sim/texel_format_to_rgba32_top_tb.sv
